### rtl/pbse_pkg.sv
// Shared constants and stage types for the scalar wire encoder.
`timescale 1ns / 1ps

package pbse_pkg;

    localparam int VALUE_W     = 64;
    localparam int CMD_W       = 3;
    localparam int BYTE_W      = 8;
    localparam int GROUP_W     = 7;
    localparam int MAX_BYTES   = 10;
    localparam int IDX_W       = 4;
    localparam int HALF_W      = 32;
    localparam int FIX32_BYTES = 4;
    localparam int FIX64_BYTES = 8;
    localparam int EXT_W       = MAX_BYTES * GROUP_W;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_VARINT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ZIGZAG32 = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ZIGZAG64 = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIXED32  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIXED64  = 3'd4;

    // Continuation flag on every varint byte but the final one
    localparam logic CONT_FLAG = 1'b1;

    // Stage 1 result: word to encode and how
    typedef struct packed {
        logic [VALUE_W-1:0] word;
        logic               varint;
        logic [IDX_W-1:0]   fixed_last;
    } prep_t;

    // Stage 2 result: all output bytes and the index of the final one
    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] lanes;
        logic [IDX_W-1:0]                 last_idx;
    } pack_t;

endpackage

### rtl/pbse_prep.sv
// Stage 1: command decode and zigzag mapping.
`timescale 1ns / 1ps

module pbse_prep
    import pbse_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [CMD_W-1:0]   in_command,
    input  logic [VALUE_W-1:0] in_value,
    output logic               out_valid,
    input  logic               out_ready,
    output prep_t              out_data
);

    logic               valid_reg;
    prep_t              data_reg;
    prep_t              data_next;
    logic               cmd_ok;
    logic [HALF_W-1:0]  low_word;
    logic [HALF_W-1:0]  zz32;
    logic [VALUE_W-1:0] zz64;

    // Zigzag maps 0,-1,1,-2,... onto 0,1,2,3,...
    assign low_word = in_value[HALF_W-1:0];
    assign zz32 = {low_word[HALF_W-2:0], 1'b0} ^ {HALF_W{low_word[HALF_W-1]}};
    assign zz64 = {in_value[VALUE_W-2:0], 1'b0} ^ {VALUE_W{in_value[VALUE_W-1]}};

    // Decode the command; unused codes produce nothing
    always_comb begin
        cmd_ok               = 1'b1;
        data_next.word       = in_value;
        data_next.varint     = 1'b1;
        data_next.fixed_last = IDX_W'(FIX64_BYTES - 1);
        unique case (in_command)
            CMD_VARINT: begin
                data_next.word = in_value;
            end
            CMD_ZIGZAG32: begin
                data_next.word = VALUE_W'(zz32);
            end
            CMD_ZIGZAG64: begin
                data_next.word = zz64;
            end
            CMD_FIXED32: begin
                data_next.word       = VALUE_W'(low_word);
                data_next.varint     = 1'b0;
                data_next.fixed_last = IDX_W'(FIX32_BYTES - 1);
            end
            CMD_FIXED64: begin
                data_next.varint = 1'b0;
            end
            default: begin
                cmd_ok = 1'b0;
            end
        endcase
    end

    assign in_ready = !valid_reg || out_ready;

    // Advance the stage when the next one can take it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid && cmd_ok;
        end
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/pbse_pack.sv
// Stage 2: split the word into byte lanes and find the final byte.
`timescale 1ns / 1ps

module pbse_pack
    import pbse_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  prep_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output pack_t out_data
);

    logic                              valid_reg;
    pack_t                             data_reg;
    pack_t                             data_next;
    logic [EXT_W-1:0]                  ext_word;
    logic [MAX_BYTES-1:0][GROUP_W-1:0] groups;
    logic [IDX_W-1:0]                  var_last;

    assign ext_word = EXT_W'(in_data.word);

    // Cut into 7-bit groups and find the highest nonzero one
    always_comb begin
        var_last = '0;
        for (int g = 0; g < MAX_BYTES; g++) begin
            groups[g] = ext_word[g*GROUP_W +: GROUP_W];
            if (|groups[g]) begin
                var_last = IDX_W'(g);
            end
        end
    end

    // Build the byte lanes for either encoding
    always_comb begin
        for (int g = 0; g < MAX_BYTES; g++) begin
            if (in_data.varint) begin
                data_next.lanes[g] = {(IDX_W'(g) < var_last) ? CONT_FLAG : 1'b0, groups[g]};
            end else if (g < FIX64_BYTES) begin
                data_next.lanes[g] = in_data.word[g*BYTE_W +: BYTE_W];
            end else begin
                data_next.lanes[g] = '0;
            end
        end
        data_next.last_idx = in_data.varint ? var_last : in_data.fixed_last;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/pbse_ser.sv
// Stage 3: emit the byte lanes one transfer at a time.
`timescale 1ns / 1ps

module pbse_ser
    import pbse_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  pack_t             in_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_byte,
    output logic              m_last
);

    logic             valid_reg;
    pack_t            data_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             at_last;

    assign at_last  = (idx_reg == data_reg.last_idx);
    assign in_ready = !valid_reg || (m_ready && at_last);

    // Load a new value after its predecessor's final transfer, else step the index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
            idx_reg   <= '0;
        end else if (m_ready) begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (in_ready) begin
            data_reg <= in_data;
        end
    end

    assign m_valid = valid_reg;
    assign m_byte  = data_reg.lanes[idx_reg];
    assign m_last  = at_last;

endmodule

### rtl/protobuf_scalar_encoder_core.sv
// Top level of the Protocol Buffers scalar wire encoder.
// Each accepted value (varint, zigzag32, zigzag64, fixed32 or fixed64 by
// command) comes out as its wire bytes, one transfer per byte, least
// significant first, with m_tlast on the final byte. The value is registered
// in the decode, pack and serializer stages in turn before m_tvalid rises. A
// value has 1 to 10 wire bytes as a varint and 4 or 8 as a fixed encoding;
// the next value's bytes follow the previous final byte without a gap when
// that value is already waiting in the pack stage. Values may be offered
// every cycle; the three stages hold them until the serializer is free.
// Commands 5 to 7 are accepted and produce no bytes.
`timescale 1ns / 1ps

module protobuf_scalar_encoder_core
    import pbse_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [2:0] command, [66:3] value, [71:67] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast
);

    logic  prep_valid;
    logic  prep_ready;
    prep_t prep_data;
    logic  pack_valid;
    logic  pack_ready;
    pack_t pack_data;

    // Decode and zigzag
    pbse_prep u_prep (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_command (s_tdata[CMD_W-1:0]),
        .in_value   (s_tdata[CMD_W +: VALUE_W]),
        .out_valid  (prep_valid),
        .out_ready  (prep_ready),
        .out_data   (prep_data)
    );

    // Byte lanes and length
    pbse_pack u_pack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (pack_valid),
        .out_ready (pack_ready),
        .out_data  (pack_data)
    );

    // Serialize onto the output stream
    pbse_ser u_ser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (pack_valid),
        .in_ready (pack_ready),
        .in_data  (pack_data),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_byte   (m_tdata),
        .m_last   (m_tlast)
    );

endmodule

### rtl/pbse_checker.sv
// Port-level assertions for the scalar encoder, bound to the top level.
`timescale 1ns / 1ps

module pbse_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [71:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    // Reset empties the output
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

    // Input backs up only when output is occupied
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with idle output");

    // Bytes of one value follow without gaps
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside an encoded value");

    // Hold a stalled transfer
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output changed");

endmodule

bind protobuf_scalar_encoder_core pbse_checker u_pbse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### dv/protobuf_scalar_encoder_core_tb.sv
// Self-checking testbench for the Protocol Buffers scalar wire encoder core.
`timescale 1ns / 1ps

module protobuf_scalar_encoder_core_tb;
    import pbse_pkg::*;

    // Commands without meaning: accepted, no bytes
    localparam logic [CMD_W-1:0] CMD_RSVD5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

    localparam int  RANDOM_ITEMS = 146;
    localparam int  QUIET_ITEMS  = 30;
    localparam int  DRAIN_CYCLES = 30;
    localparam time RUN_LIMIT    = 5ms;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } wire_byte_t;

    // Predicts the wire bytes of each accepted value and checks the output stream
    class encoder_scoreboard;
        wire_byte_t wire_bytes_due[$];
        int         mismatch_count = 0;

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            mismatch_count++;
        endtask

        function void queue_varint_bytes(logic [VALUE_W-1:0] x);
            wire_byte_t b;
            while (x > 64'h7f) begin
                b.data = {1'b1, x[GROUP_W-1:0]};
                b.last = 1'b0;
                wire_bytes_due.push_back(b);
                x = x >> GROUP_W;
            end
            b.data = {1'b0, x[GROUP_W-1:0]};
            b.last = 1'b1;
            wire_bytes_due.push_back(b);
        endfunction

        function void queue_fixed_bytes(logic [VALUE_W-1:0] x, int nbytes);
            wire_byte_t b;
            for (int i = 0; i < nbytes; i++) begin
                b.data = x[BYTE_W-1:0];
                b.last = (i == nbytes - 1);
                wire_bytes_due.push_back(b);
                x = x >> BYTE_W;
            end
        endfunction

        // Note one accepted value and expand it into its expected bytes
        function void note_value(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] v);
            logic [HALF_W-1:0]  w;
            logic [HALF_W-1:0]  z32;
            logic [VALUE_W-1:0] z64;
            w   = v[HALF_W-1:0];
            z32 = {w[HALF_W-2:0], 1'b0} ^ {HALF_W{w[HALF_W-1]}};
            z64 = {v[VALUE_W-2:0], 1'b0} ^ {VALUE_W{v[VALUE_W-1]}};
            case (cmd)
                CMD_VARINT:   queue_varint_bytes(v);
                CMD_ZIGZAG32: queue_varint_bytes({32'd0, z32});
                CMD_ZIGZAG64: queue_varint_bytes(z64);
                CMD_FIXED32:  queue_fixed_bytes({32'd0, w}, FIX32_BYTES);
                CMD_FIXED64:  queue_fixed_bytes(v, FIX64_BYTES);
                default: ;
            endcase
        endfunction

        // Compare one output transfer with the oldest expected byte
        task check_byte(logic [BYTE_W-1:0] data, logic last);
            wire_byte_t exp_b;
            if (wire_bytes_due.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %02h last %0b", data, last));
            end else begin
                exp_b = wire_bytes_due.pop_front();
                if (data !== exp_b.data)
                    report_mismatch($sformatf("byte %02h, expected %02h", data, exp_b.data));
                if (last !== exp_b.last)
                    report_mismatch($sformatf("last %0b, expected %0b on byte %02h",
                                              last, exp_b.last, exp_b.data));
            end
        endtask

        function int pending();
            return wire_bytes_due.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // [2:0] command, [66:3] value, [71:67] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] out_byte
    logic        m_tlast;

    encoder_scoreboard board;
    bit                idle_en;

    protobuf_scalar_encoder_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #(RUN_LIMIT);
        $display("protobuf_scalar_encoder_core_tb NOT OK");
        $finish;
    end

    // Offer one value and hold it until the transfer
    task drive_value(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] v);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, v, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_value(cmd, v);
    endtask

    // Drop valid for a burst of cycles
    task sender_gap(int n);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tdata  <= {$urandom, $urandom, 8'($urandom)};
        repeat (n - 1) @(negedge aclk);
    endtask

    task maybe_sender_gap();
        if (idle_en && $urandom_range(0, 3) == 0)
            sender_gap($urandom_range(1, 17));
    endtask

    // Random value of random magnitude, sometimes inverted to reach negatives
    function logic [VALUE_W-1:0] random_value();
        logic [VALUE_W-1:0] v;
        int                 bits;
        v    = {$urandom, $urandom};
        bits = $urandom_range(0, VALUE_W);
        if (bits < VALUE_W)
            v = v & ((64'd1 << bits) - 64'd1);
        if ($urandom_range(0, 3) == 0)
            v = ~v;
        return v;
    endfunction

    // Receiver: ready in random bursts, always ready once idling stops
    initial begin
        m_tready = 1'b0;
        forever begin
            if (idle_en && $urandom_range(0, 2) == 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge aclk);
            end else begin
                @(negedge aclk);
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20) - 1) @(negedge aclk);
            end
        end
    end

    // Check every output transfer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_byte(m_tdata, m_tlast);
    end

    // Stimulus
    initial begin
        logic [CMD_W-1:0] cmd;
        board    = new();
        idle_en  = 1'b1;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: zero, group boundaries, extremes of each encoding
        drive_value(CMD_VARINT,   64'd0);
        drive_value(CMD_VARINT,   64'd127);
        drive_value(CMD_VARINT,   64'd128);
        drive_value(CMD_VARINT,   64'hffff_ffff_ffff_ffff);
        drive_value(CMD_VARINT,   64'h8000_0000_0000_0000);
        drive_value(CMD_ZIGZAG32, 64'd0);
        drive_value(CMD_ZIGZAG32, 64'h0000_0000_ffff_ffff);
        drive_value(CMD_ZIGZAG32, 64'h0000_0000_7fff_ffff);
        // sign of the low word only, upper bits must not leak in
        drive_value(CMD_ZIGZAG32, 64'hffff_ffff_8000_0000);
        drive_value(CMD_ZIGZAG32, 64'h5a5a_5a5a_0000_0001);
        drive_value(CMD_ZIGZAG64, 64'd0);
        drive_value(CMD_ZIGZAG64, 64'hffff_ffff_ffff_ffff);
        drive_value(CMD_ZIGZAG64, 64'h7fff_ffff_ffff_ffff);
        drive_value(CMD_ZIGZAG64, 64'h8000_0000_0000_0000);
        drive_value(CMD_FIXED32,  64'd0);
        drive_value(CMD_FIXED32,  64'hffff_ffff_ffff_ffff);
        drive_value(CMD_FIXED32,  64'h1234_5678_89ab_cdef);
        drive_value(CMD_FIXED64,  64'd0);
        drive_value(CMD_FIXED64,  64'hffff_ffff_ffff_ffff);
        drive_value(CMD_FIXED64,  64'h0123_4567_89ab_cdef);
        drive_value(CMD_RSVD5,    64'hffff_ffff_ffff_ffff);
        drive_value(CMD_RSVD6,    64'd1);
        drive_value(CMD_RSVD7,    64'h8000_0000_0000_0000);
        drive_value(CMD_VARINT,   64'd1);

        // Hold off the sender until the output stream has drained
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (board.pending() > 0) @(posedge aclk);

        // Random: mostly real commands, a few unused ones
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - QUIET_ITEMS)
                idle_en = 1'b0;
            maybe_sender_gap();
            if ($urandom_range(0, 11) == 0)
                cmd = CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7));
            else
                cmd = CMD_W'($urandom_range(CMD_VARINT, CMD_FIXED64));
            drive_value(cmd, random_value());
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        // Drain, then keep watching for stray bytes
        while (board.pending() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.mismatch_count == 0)
            $display("protobuf_scalar_encoder_core_tb OK");
        else
            $display("protobuf_scalar_encoder_core_tb NOT OK");
        $finish;
    end

endmodule
